FILE: hdl/harmonic_oscillator_euler_stepper_macros.svh
// assertion macros for the oscillator stepper
`ifndef HARMONIC_OSCILLATOR_EULER_STEPPER_MACROS_SVH
`define HARMONIC_OSCILLATOR_EULER_STEPPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HOES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HOES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hoes_pkg.sv
// constants and register codes for the oscillator stepper
package hoes_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int DT_EXTRA         = 8;
  localparam int MAX_SUBDIVISIONS = 1023;
  localparam int MAX_SAMPLES      = 1048576;

  localparam int DATA_W  = 32;
  localparam int SUB_W   = 10;
  localparam int CNT_W   = 21;
  localparam int DT_W    = DATA_W + DT_EXTRA;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int WIDE_W  = PROD_W + DT_EXTRA;
  localparam int IDX_W   = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_OMEGA            = 3'd0;
  localparam logic [IDX_W-1:0] REG_SAMPLE_STEP      = 3'd1;
  localparam logic [IDX_W-1:0] REG_SUBDIVISIONS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_INITIAL_POSITION = 3'd3;
  localparam logic [IDX_W-1:0] REG_INITIAL_VELOCITY = 3'd4;
  localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT     = 3'd5;

  // register reset values
  localparam logic [DATA_W-1:0] RST_OMEGA       = 32'd655360;
  localparam logic [DATA_W-1:0] RST_SAMPLE_STEP = 32'd65536;
  localparam logic [SUB_W-1:0]  RST_SUBDIV      = 10'd1;
  localparam logic [DATA_W-1:0] RST_INIT_POS    = 32'd65536;
  localparam logic [DATA_W-1:0] RST_INIT_VEL    = 32'd0;
  localparam logic [CNT_W-1:0]  RST_SAMPLE_CNT  = 21'd1024;

endpackage

FILE: hdl/harmonic_oscillator_euler_stepper.sv
// Semi-implicit Euler harmonic oscillator stepper in signed fixed point
//
// Channels: in_* carries one tick (in_restart), out_* one position sample
// with last_sample and saturated flags, cfg_* writes the six run registers
// (omega, sample_step, subdivisions, initial_position, initial_velocity,
// sample_count) and is always ready. All channels use valid/ready.
// A restart tick reloads position and velocity and divides sample_step by
// the substep count in a bit-serial divider, one quotient bit per cycle.
// A tick of a run (a restart after its divide) moves its sample from the
// emit step into the output register once that register is free, then runs
// the substeps on one shared 32x32 multiplier and saturator under the
// sequencer: position times omega twice and times dt updates velocity, then
// velocity times dt updates position. in_ready stays low until the last
// substep ends; a tick with no run active is dropped, in_ready staying high.
// A stalled receiver holds the sample in the output register; the next
// sample waits in the emit step until that register is free.
// After reset no run is active and the registers hold their defaults.
`include "harmonic_oscillator_euler_stepper_macros.svh"

module harmonic_oscillator_euler_stepper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hoes_pkg::DATA_W-1:0]  out_position,
  output logic                                out_last_sample,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [hoes_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [hoes_pkg::DATA_W-1:0]  cfg_data
);
  import hoes_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_EMIT = 4'd2;
  localparam logic [3:0] ST_LDP  = 4'd3;
  localparam logic [3:0] ST_MULL = 4'd4;
  localparam logic [3:0] ST_MULH = 4'd5;
  localparam logic [3:0] ST_SAT  = 4'd6;
  localparam logic [3:0] ST_VEL  = 4'd7;
  localparam logic [3:0] ST_LDV  = 4'd8;
  localparam logic [3:0] ST_POS  = 4'd9;

  localparam logic [1:0] OP_T1  = 2'd0;
  localparam logic [1:0] OP_ACC = 2'd1;
  localparam logic [1:0] OP_DV  = 2'd2;
  localparam logic [1:0] OP_DX  = 2'd3;

  localparam int DCNT_W = $clog2(DT_W);

  // configuration
  logic [DATA_W-1:0] omega_r, sample_step_r, init_pos_r, init_vel_r;
  logic [SUB_W-1:0]  subdiv_r;
  logic [CNT_W-1:0]  sample_cnt_r;

  // sequencer and datapath
  logic [3:0]               state_r;
  logic [1:0]               op_r;
  logic [DATA_W-1:0]        amag_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        prod_r;
  logic [DT_W-1:0]          hi_r;
  logic signed [DATA_W-1:0] res_r, pos_r, vel_r;
  logic [DT_W-1:0]          dt_r;
  logic [SUB_W-1:0]         rem_r;
  logic [DCNT_W-1:0]        div_cnt_r;
  logic [SUB_W-1:0]         sub_cnt_r;
  logic [CNT_W-1:0]         idx_r;
  logic                     run_done_r, sat_seen_r;
  logic                     out_valid_r;

  logic [SUB_W-1:0]         subs_eff;
  logic [CNT_W-1:0]         cnt_eff;
  logic                     uses_omega;
  logic [DATA_W-1:0]        mul_b;
  logic [PROD_W-1:0]        prod;
  logic [WIDE_W-1:0]        q_full, limit;
  logic                     mul_sat;
  logic [DATA_W-1:0]        q_mag;
  logic signed [DATA_W-1:0] res_nxt, vel_nxt, pos_nxt, ld_src;
  logic [DATA_W-1:0]        ld_mag;
  logic [DATA_W:0]          vel_diff, pos_sum;
  logic                     vel_sat, pos_sat;
  logic                     last_nxt, sub_last;
  logic [SUB_W:0]           div_shift;
  logic                     div_ge;
  logic [SUB_W-1:0]         rem_nxt;
  logic                     in_xfer, emit_go;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    if (subdiv_r == '0) begin
      subs_eff = SUB_W'(1);
    end else if (subdiv_r > SUB_W'(MAX_SUBDIVISIONS)) begin
      subs_eff = SUB_W'(MAX_SUBDIVISIONS);
    end else begin
      subs_eff = subdiv_r;
    end
    if (sample_cnt_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (sample_cnt_r > CNT_W'(MAX_SAMPLES)) begin
      cnt_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      cnt_eff = sample_cnt_r;
    end
  end

  assign last_nxt = ({1'b0, idx_r} + (CNT_W+1)'(1)) >= {1'b0, cnt_eff};
  assign sub_last = ({1'b0, sub_cnt_r} + (SUB_W+1)'(1)) >= {1'b0, subs_eff};

  // restoring divider step, one quotient bit per cycle
  assign div_shift = {rem_r, dt_r[DT_W-1]};
  assign div_ge    = div_shift >= {1'b0, subs_eff};
  assign rem_nxt   = div_ge ? SUB_W'(div_shift - {1'b0, subs_eff}) : div_shift[SUB_W-1:0];

  // shared multiplier: omega for the acceleration chain, dt in two halves
  assign uses_omega = (op_r == OP_T1) || (op_r == OP_ACC);
  always_comb begin
    if (state_r == ST_MULH) begin
      mul_b = DATA_W'(dt_r >> DATA_W);
    end else if (uses_omega) begin
      mul_b = omega_r;
    end else begin
      mul_b = dt_r[DATA_W-1:0];
    end
  end
  assign prod = PROD_W'(amag_r) * PROD_W'(mul_b);

  // shift magnitude toward zero, then saturate against the signed limit
  always_comb begin
    if (uses_omega) begin
      q_full = WIDE_W'(prod_r >> FRAC_BITS);
    end else begin
      q_full = ({hi_r, {DATA_W{1'b0}}} + WIDE_W'(prod_r)) >> (FRAC_BITS + DT_EXTRA);
    end
    limit   = neg_r ? WIDE_W'(33'h080000000) : WIDE_W'(33'h07FFFFFFF);
    mul_sat = q_full > limit;
    q_mag   = mul_sat ? limit[DATA_W-1:0] : q_full[DATA_W-1:0];
    res_nxt = neg_r ? -$signed(q_mag) : $signed(q_mag);
  end

  always_comb begin
    vel_diff = {vel_r[DATA_W-1], vel_r} - {res_r[DATA_W-1], res_r};
    vel_sat  = vel_diff[DATA_W] != vel_diff[DATA_W-1];
    if (vel_sat) begin
      vel_nxt = vel_diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      vel_nxt = vel_diff[DATA_W-1:0];
    end
    pos_sum = {pos_r[DATA_W-1], pos_r} + {res_r[DATA_W-1], res_r};
    pos_sat = pos_sum[DATA_W] != pos_sum[DATA_W-1];
    if (pos_sat) begin
      pos_nxt = pos_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      pos_nxt = pos_sum[DATA_W-1:0];
    end
    ld_src = (state_r == ST_LDV) ? vel_r : pos_r;
    ld_mag = ld_src[DATA_W-1] ? DATA_W'(-ld_src) : DATA_W'(ld_src);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r       <= RST_OMEGA;
      sample_step_r <= RST_SAMPLE_STEP;
      subdiv_r      <= RST_SUBDIV;
      init_pos_r    <= RST_INIT_POS;
      init_vel_r    <= RST_INIT_VEL;
      sample_cnt_r  <= RST_SAMPLE_CNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OMEGA:            omega_r       <= cfg_data;
        REG_SAMPLE_STEP:      sample_step_r <= cfg_data;
        REG_SUBDIVISIONS:     subdiv_r      <= cfg_data[SUB_W-1:0];
        REG_INITIAL_POSITION: init_pos_r    <= cfg_data;
        REG_INITIAL_VELOCITY: init_vel_r    <= cfg_data;
        REG_SAMPLE_COUNT:     sample_cnt_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_position    <= pos_r;
      out_last_sample <= last_nxt;
      out_saturated   <= sat_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      run_done_r <= 1'b1;
      sat_seen_r <= 1'b0;
      idx_r      <= '0;
      sub_cnt_r  <= '0;
      div_cnt_r  <= '0;
      op_r       <= OP_T1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_restart) begin
              pos_r      <= init_pos_r;
              vel_r      <= init_vel_r;
              dt_r       <= DT_W'(sample_step_r) << DT_EXTRA;
              rem_r      <= '0;
              div_cnt_r  <= '0;
              idx_r      <= '0;
              run_done_r <= 1'b0;
              sat_seen_r <= 1'b0;
              state_r    <= ST_DIV;
            end else if (!run_done_r) begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          dt_r      <= {dt_r[DT_W-2:0], div_ge};
          rem_r     <= rem_nxt;
          div_cnt_r <= div_cnt_r + DCNT_W'(1);
          if (div_cnt_r == DCNT_W'(DT_W - 1)) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (last_nxt) begin
              run_done_r <= 1'b1;
            end else begin
              idx_r <= idx_r + CNT_W'(1);
            end
            sub_cnt_r <= '0;
            state_r   <= ST_LDP;
          end
        end
        ST_LDP: begin
          amag_r  <= ld_mag;
          neg_r   <= pos_r[DATA_W-1];
          op_r    <= OP_T1;
          state_r <= ST_MULL;
        end
        ST_MULL: begin
          prod_r  <= prod;
          state_r <= uses_omega ? ST_SAT : ST_MULH;
        end
        ST_MULH: begin
          hi_r    <= prod[DT_W-1:0];
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (mul_sat) begin
            sat_seen_r <= 1'b1;
          end
          case (op_r)
            OP_T1: begin
              // sign carries through the omega chain unchanged
              amag_r  <= q_mag;
              op_r    <= OP_ACC;
              state_r <= ST_MULL;
            end
            OP_ACC: begin
              amag_r  <= q_mag;
              op_r    <= OP_DV;
              state_r <= ST_MULL;
            end
            OP_DV: begin
              res_r   <= res_nxt;
              state_r <= ST_VEL;
            end
            OP_DX: begin
              res_r   <= res_nxt;
              state_r <= ST_POS;
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_VEL: begin
          vel_r <= vel_nxt;
          if (vel_sat) begin
            sat_seen_r <= 1'b1;
          end
          state_r <= ST_LDV;
        end
        ST_LDV: begin
          amag_r  <= ld_mag;
          neg_r   <= vel_r[DATA_W-1];
          op_r    <= OP_DX;
          state_r <= ST_MULL;
        end
        ST_POS: begin
          pos_r <= pos_nxt;
          if (pos_sat) begin
            sat_seen_r <= 1'b1;
          end
          if (sub_last) begin
            // leave the counter at zero so a new substep count is safe
            sub_cnt_r <= '0;
            state_r   <= ST_IDLE;
          end else begin
            sub_cnt_r <= sub_cnt_r + SUB_W'(1);
            state_r   <= ST_LDP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `HOES_ASSERT_NEXT(a_idle_tick_dropped, in_xfer && !in_restart && run_done_r, in_ready, "tick with no run did not return to idle")
  `HOES_ASSERT_NEXT(a_restart_divides, in_xfer && in_restart, state_r == ST_DIV, "restart did not start the divider")
  `HOES_ASSERT_NEXT(a_emit_waits, state_r == ST_EMIT && out_valid_r && !out_ready, state_r == ST_EMIT && out_valid_r, "sample overwrote a stalled output")
  `HOES_ASSERT_NOW(a_substep_bound, state_r != ST_IDLE, sub_cnt_r < subs_eff, "substep counter past subdivisions")

endmodule
